// ----- sv/usbcrr_pkg.sv -----
// Shared types, request codes and descriptor tables of the control request responder.
`timescale 1ns / 1ps
`default_nettype none

package usbcrr_pkg;

  // Defaults for the top-level parameters.
  localparam int BAUD_BYTES_DEF       = 4;
  localparam int CHAR_BYTES_DEF       = 6;
  localparam int MAX_STRING_CHARS_DEF = 31;

  // Longest reply is a string descriptor of 18 characters: 38 beats.
  localparam int LEN_W  = 6;
  localparam int CHAR_W = 5;

  typedef enum logic [1:0] {
    MODE_SETUP       = 2'd0,
    MODE_EMPTY_SETUP = 2'd1,
    MODE_DATA        = 2'd2,
    MODE_EMPTY_DATA  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_DATA = 2'd0,
    ACT_ZLP  = 2'd1,
    ACT_NONE = 2'd2,
    ACT_ERR  = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    SRC_FIXED = 3'd0,
    SRC_DEV   = 3'd1,
    SRC_CFG   = 3'd2,
    SRC_LANG  = 3'd3,
    SRC_STR   = 3'd4
  } src_e;

  typedef enum logic [1:0] {
    CAP_NONE  = 2'd0,
    CAP_BAUD  = 2'd1,
    CAP_CHARS = 2'd2
  } cap_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // One reply job handed from the decoder to the streamer.
  typedef struct packed {
    src_e              src;
    act_e              act;
    logic [7:0]        fixed_byte;
    logic [LEN_W-1:0]  len;
    logic [1:0]        str_sel;
    logic [CHAR_W-1:0] str_chars;
  } job_t;

  localparam logic [7:0]  TYPE_CLASS      = 8'h21;

  localparam logic [15:0] TAG_GET_DESC    = 16'h8006;
  localparam logic [15:0] TAG_SET_ADDR    = 16'h0005;
  localparam logic [15:0] TAG_SET_CONFIG  = 16'h0009;
  localparam logic [15:0] TAG_VEND_READ   = 16'hc0ff;
  localparam logic [15:0] TAG_UART_ENABLE = 16'h4100;
  localparam logic [15:0] TAG_SET_BAUD    = 16'h411e;
  localparam logic [15:0] TAG_SET_LINE    = 16'h4103;
  localparam logic [15:0] TAG_SET_CHARS   = 16'h4119;
  localparam logic [15:0] TAG_GET_STATUS  = 16'hc114;
  localparam logic [15:0] TAG_GET_MODEM   = 16'hc108;
  localparam logic [15:0] TAG_SET_MODEM   = 16'h4107;
  localparam logic [15:0] TAG_GET_COMM    = 16'hc110;

  localparam logic [7:0]  DESC_DEVICE     = 8'h01;
  localparam logic [7:0]  DESC_CONFIG     = 8'h02;
  localparam logic [7:0]  DESC_STRING     = 8'h03;
  localparam logic [7:0]  DESC_QUALIFIER  = 8'h06;

  localparam logic [7:0]  VEND_READ_BYTE  = 8'h02;
  localparam logic [7:0]  STRING_TYPE     = 8'h03;

  localparam logic [LEN_W-1:0] DEV_LEN  = 6'd18;
  localparam logic [LEN_W-1:0] CFG_LEN  = 6'd32;
  localparam logic [LEN_W-1:0] LANG_LEN = 6'd4;

  localparam logic [7:0] DEV_ROM [18] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'hc4,
    8'h10, 8'h60, 8'hea, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01};

  localparam logic [7:0] CFG_ROM [32] = '{
    8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hc0, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hff, 8'h00, 8'h00, 8'h02,
    8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00};

  localparam logic [7:0] LANG_ROM [4] = '{8'h04, 8'h03, 8'h09, 8'h04};

  localparam logic [CHAR_W-1:0] TEXT_LEN [3] = '{5'd14, 5'd18, 5'd4};

  localparam logic [7:0] TEXT_ROM [3][18] = '{
    '{8'h41, 8'h43, 8'h4d, 8'h45, 8'h20, 8'h63, 8'h6f, 8'h6d, 8'h70,
      8'h75, 8'h74, 8'h65, 8'h72, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h42, 8'h61, 8'h73, 8'h69, 8'h63, 8'h20, 8'h63, 8'h6f, 8'h6e,
      8'h73, 8'h6f, 8'h6c, 8'h65, 8'h20, 8'h70, 8'h6f, 8'h72, 8'h74},
    '{8'h31, 8'h32, 8'h33, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}};

endpackage

`default_nettype wire

// ----- sv/usb_control_request_responder.sv -----
// Top level of the USB control request responder: request decode, device flags, capture store.
//
// One input beat is one control event: a setup packet, an empty setup packet,
// one control OUT data byte, or an empty control data packet. It is accepted
// when in_valid_i is high and in_stall_o is low. Each event yields one to 38
// result beats on the output channel, taken when out_valid_o is high and
// out_stall_i is low; last_o marks the final beat of the event.
// The event is decoded in the cycle it is accepted and the device flags and
// capture store take their new values then. A beat counter then walks the
// descriptor tables, one result beat per cycle while the receiver does not
// stall. The job and counter are registered at acceptance, and each beat
// then passes through the output register before it is shown. in_stall_o
// stays high until the last beat has been taken. A receiver stall holds the
// output register and the counter; nothing is lost. Status outputs show the
// state after the event whose beats are being delivered.
// Reset clears all flags, the pending address, the capture mode and both
// capture stores, and empties the output register.

`timescale 1ns / 1ps
`default_nettype none

module usb_control_request_responder
  import usbcrr_pkg::*;
#(
  parameter int BAUD_BYTES       = BAUD_BYTES_DEF,
  parameter int CHAR_BYTES       = CHAR_BYTES_DEF,
  parameter int MAX_STRING_CHARS = MAX_STRING_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  byte_offset_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [7:0]  reply_byte_o,
  output logic        last_o,
  output logic        configured_o,
  output logic        uart_enabled_o,
  output logic        terminal_ready_o,
  output logic        address_valid_o,
  output logic [6:0]  device_address_o,
  output logic [31:0] baud_setting_o,
  output logic [47:0] special_chars_o
);

  logic       busy;
  logic       accept;
  job_t       job_d;

  logic       configured_q, configured_d;
  logic       uart_q, uart_d;
  logic       dtr_q, dtr_d;
  logic [7:0] addr_q, addr_d;
  cap_e       cap_q, cap_d;
  logic       baud_we, chars_we;

  logic [7:0] baud_q  [BAUD_BYTES];
  logic [7:0] chars_q [CHAR_BYTES];

  logic [CHAR_W-1:0] str_chars;
  logic [1:0]        str_sel;

  assign accept     = in_valid_i && !busy;
  assign in_stall_o = busy;

  assign str_sel   = 2'(request_value_i[7:0] - 8'd1);
  assign str_chars = (int'(TEXT_LEN[str_sel]) > MAX_STRING_CHARS) ?
                     CHAR_W'(MAX_STRING_CHARS) : TEXT_LEN[str_sel];

  always_comb begin
    job_d            = '0;
    job_d.src        = SRC_FIXED;
    job_d.act        = ACT_NONE;
    job_d.len        = LEN_W'(1);
    configured_d     = configured_q;
    uart_d           = uart_q;
    dtr_d            = dtr_q;
    addr_d           = addr_q;
    cap_d            = cap_q;
    baud_we          = 1'b0;
    chars_we         = 1'b0;
    case (mode_e'(mode_i))
      MODE_SETUP: begin
        if (request_type_i == TYPE_CLASS) begin
          job_d.act = ACT_ZLP;
        end else begin
          // Every non-class setup ends a pending capture before it is decoded.
          cap_d = CAP_NONE;
          case ({request_type_i, request_code_i})
            TAG_GET_DESC: begin
              case (request_value_i[15:8])
                DESC_DEVICE: begin
                  job_d.src = SRC_DEV;
                  job_d.act = ACT_DATA;
                  job_d.len = DEV_LEN;
                end
                DESC_QUALIFIER: job_d.act = ACT_ZLP;
                DESC_CONFIG: begin
                  if (request_length_i == 16'd0) begin
                    job_d.act = ACT_ZLP;
                  end else begin
                    job_d.src = SRC_CFG;
                    job_d.act = ACT_DATA;
                    job_d.len = (request_length_i < 16'(CFG_LEN)) ?
                                request_length_i[LEN_W-1:0] : CFG_LEN;
                  end
                end
                DESC_STRING: begin
                  if (request_value_i[7:0] == 8'd0) begin
                    job_d.src = SRC_LANG;
                    job_d.act = ACT_DATA;
                    job_d.len = LANG_LEN;
                  end else if (request_value_i[7:0] > 8'd3) begin
                    job_d.act = ACT_ERR;
                  end else begin
                    job_d.src       = SRC_STR;
                    job_d.act       = ACT_DATA;
                    job_d.str_sel   = str_sel;
                    job_d.str_chars = str_chars;
                    job_d.len       = LEN_W'({str_chars, 1'b0}) + LEN_W'(2);
                  end
                end
                default: job_d.act = ACT_NONE;
              endcase
            end
            TAG_SET_ADDR: begin
              addr_d    = {1'b1, request_value_i[6:0]};
              job_d.act = ACT_ZLP;
            end
            TAG_SET_CONFIG: begin
              configured_d = 1'b1;
              job_d.act    = ACT_ZLP;
            end
            TAG_VEND_READ: begin
              job_d.act        = ACT_DATA;
              job_d.fixed_byte = VEND_READ_BYTE;
            end
            TAG_UART_ENABLE: begin
              uart_d    = (request_value_i == 16'd1);
              job_d.act = ACT_ZLP;
            end
            TAG_SET_BAUD: begin
              cap_d     = CAP_BAUD;
              job_d.act = ACT_ZLP;
            end
            TAG_SET_LINE:   job_d.act = ACT_ZLP;
            TAG_SET_CHARS: begin
              cap_d     = CAP_CHARS;
              job_d.act = ACT_ZLP;
            end
            TAG_GET_STATUS: job_d.act = ACT_ZLP;
            TAG_GET_MODEM:  job_d.act = ACT_DATA;
            TAG_SET_MODEM: begin
              if (request_value_i[0]) dtr_d = 1'b1;
              job_d.act = ACT_ZLP;
            end
            TAG_GET_COMM: begin
              job_d.act = ACT_DATA;
              job_d.len = LEN_W'(2);
            end
            default: job_d.act = ACT_NONE;
          endcase
        end
      end
      MODE_EMPTY_SETUP: job_d.act = ACT_NONE;
      MODE_DATA: begin
        if (cap_q == CAP_BAUD) begin
          baud_we   = 1'b1;
          job_d.act = ACT_NONE;
        end else if (cap_q == CAP_CHARS) begin
          chars_we  = 1'b1;
          job_d.act = ACT_NONE;
        end else begin
          job_d.act = end_of_packet_i ? ACT_ZLP : ACT_NONE;
        end
      end
      MODE_EMPTY_DATA: job_d.act = (cap_q != CAP_NONE) ? ACT_NONE : ACT_ZLP;
      default: job_d.act = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      configured_q <= 1'b0;
      uart_q       <= 1'b0;
      dtr_q        <= 1'b0;
      addr_q       <= 8'd0;
      cap_q        <= CAP_NONE;
    end else if (accept) begin
      configured_q <= configured_d;
      uart_q       <= uart_d;
      dtr_q        <= dtr_d;
      addr_q       <= addr_d;
      cap_q        <= cap_d;
    end
  end

  // Capture stores; a byte whose offset falls past the store matches no entry.
  for (genvar i = 0; i < BAUD_BYTES; i++) begin : g_baud
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        baud_q[i] <= 8'd0;
      end else if (accept && baud_we && (int'(byte_offset_i) == i)) begin
        baud_q[i] <= data_byte_i;
      end
    end
  end

  for (genvar i = 0; i < CHAR_BYTES; i++) begin : g_chars
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        chars_q[i] <= 8'd0;
      end else if (accept && chars_we && (int'(byte_offset_i) == i)) begin
        chars_q[i] <= data_byte_i;
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_baud_out
    if (i < BAUD_BYTES) begin : g_used
      assign baud_setting_o[8*i +: 8] = baud_q[i];
    end else begin : g_pad
      assign baud_setting_o[8*i +: 8] = 8'd0;
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_chars_out
    if (i < CHAR_BYTES) begin : g_used
      assign special_chars_o[8*i +: 8] = chars_q[i];
    end else begin : g_pad
      assign special_chars_o[8*i +: 8] = 8'd0;
    end
  end

  usbcrr_streamer u_streamer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .job_i        (job_d),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .action_o     (action_o),
    .reply_byte_o (reply_byte_o),
    .last_o       (last_o)
  );

  assign configured_o     = configured_q;
  assign uart_enabled_o   = uart_q;
  assign terminal_ready_o = dtr_q;
  assign address_valid_o  = addr_q[7];
  assign device_address_o = addr_q[6:0];

  // Every event produces a reply, so the block must hold off the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted without the block going busy");

  // Nothing follows the final beat until a new event is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o)
    else $error("result beat after the final beat of an event");

  // Acknowledge, no-reply and error results stand alone and carry no byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o != ACT_DATA)) |-> (last_o && (reply_byte_o == 8'd0)))
    else $error("non-data result is not a single empty beat");

  // A shown result belongs to an event still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input ready while results are pending");

endmodule

`default_nettype wire

// ----- sv/usbcrr_rom.sv -----
// Descriptor byte lookup: maps a reply source and beat position to a byte.
`timescale 1ns / 1ps
`default_nettype none

module usbcrr_rom
  import usbcrr_pkg::*;
(
  input  job_t             job_i,
  input  logic [LEN_W-1:0] pos_i,
  output logic [7:0]       byte_o
);

  logic [LEN_W-1:0] str_pos;

  assign str_pos = pos_i - LEN_W'(2);

  always_comb begin
    case (job_i.src)
      SRC_FIXED: byte_o = job_i.fixed_byte;
      SRC_DEV:   byte_o = DEV_ROM[pos_i[4:0]];
      SRC_CFG:   byte_o = CFG_ROM[pos_i[4:0]];
      SRC_LANG:  byte_o = LANG_ROM[pos_i[1:0]];
      SRC_STR: begin
        // Header is length and type, then each ASCII char widened to UTF-16LE.
        if (pos_i == LEN_W'(0)) begin
          byte_o = 8'({job_i.str_chars, 1'b0}) + 8'd2;
        end else if (pos_i == LEN_W'(1)) begin
          byte_o = STRING_TYPE;
        end else if (str_pos[0]) begin
          byte_o = 8'h00;
        end else begin
          byte_o = TEXT_ROM[job_i.str_sel][str_pos[5:1]];
        end
      end
      default:   byte_o = 8'h00;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/usbcrr_streamer.sv -----
// Reply sequencer: steps a beat counter through the ROM lookup into an output register.
`timescale 1ns / 1ps
`default_nettype none

module usbcrr_streamer
  import usbcrr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  job_t       job_i,
  output logic       busy_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] action_o,
  output logic [7:0] reply_byte_o,
  output logic       last_o
);

  state_e           state_q, state_d;
  job_t             job_q;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       action_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic [7:0]       rom_byte;
  logic             advance;
  logic             last_beat;

  usbcrr_rom u_rom (
    .job_i  (job_q),
    .pos_i  (cnt_q),
    .byte_o (rom_byte)
  );

  // While a reply runs, a new beat is produced whenever the output register is free or drains now.
  assign advance   = (state_q == ST_RUN) && (!out_valid_q || !out_stall_i);
  assign last_beat = (cnt_q == job_q.len - LEN_W'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_RUN;
      ST_RUN:  if (advance && last_beat) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (start_i) begin
      cnt_d = '0;
    end else if (advance) begin
      cnt_d = cnt_q + LEN_W'(1);
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      job_q <= job_i;
    end
    if (advance) begin
      action_q <= job_q.act;
      byte_q   <= rom_byte;
      last_q   <= last_beat;
    end
  end

  assign busy_o       = (state_q == ST_RUN) || out_valid_q;
  assign out_valid_o  = out_valid_q;
  assign action_o     = action_q;
  assign reply_byte_o = byte_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ----- test/tb_usb_control_request_responder.sv -----
// Self-checking testbench for the USB control request responder.
`timescale 1ns / 1ps

import usbcrr_pkg::*;

// Descriptor contents as the host should see them.
localparam logic [7:0] DEVICE_BYTES [18] = '{
  8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'hc4,
  8'h10, 8'h60, 8'hea, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01};

localparam logic [7:0] CONFIG_BYTES [32] = '{
  8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hc0, 8'h32,
  8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hff, 8'h00, 8'h00, 8'h02,
  8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
  8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00};

localparam logic [7:0] LANGUAGE_BYTES [4] = '{8'h04, 8'h03, 8'h09, 8'h04};

localparam int TEXT_CHARS [3] = '{14, 18, 4};

localparam logic [7:0] TEXT_BYTES [3][18] = '{
  '{8'h41, 8'h43, 8'h4d, 8'h45, 8'h20, 8'h63, 8'h6f, 8'h6d, 8'h70,
    8'h75, 8'h74, 8'h65, 8'h72, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00},
  '{8'h42, 8'h61, 8'h73, 8'h69, 8'h63, 8'h20, 8'h63, 8'h6f, 8'h6e,
    8'h73, 8'h6f, 8'h6c, 8'h65, 8'h20, 8'h70, 8'h6f, 8'h72, 8'h74},
  '{8'h31, 8'h32, 8'h33, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}};

localparam logic [15:0] KNOWN_TAGS [12] = '{
  TAG_GET_DESC, TAG_SET_ADDR, TAG_SET_CONFIG, TAG_VEND_READ, TAG_UART_ENABLE,
  TAG_SET_BAUD, TAG_SET_LINE, TAG_SET_CHARS, TAG_GET_STATUS, TAG_GET_MODEM,
  TAG_SET_MODEM, TAG_GET_COMM};

typedef struct packed {
  mode_e       mode;
  logic [7:0]  rtype;
  logic [7:0]  code;
  logic [15:0] value;
  logic [15:0] length;
  logic [7:0]  data;
  logic [5:0]  offset;
  logic        eop;
} ctrl_event_t;

typedef struct packed {
  act_e        act;
  logic [7:0]  data;
  logic        last;
  logic        configured;
  logic        uart_on;
  logic        dtr;
  logic        addr_ok;
  logic [6:0]  addr;
  logic [31:0] baud;
  logic [47:0] chars;
} reply_beat_t;

class reply_tracker;
  bit          configured;
  bit          uart_on;
  bit          dtr_seen;
  bit          addr_ok;
  logic [6:0]  addr;
  cap_e        capture;
  logic [7:0]  baud_b [BAUD_BYTES_DEF];
  logic [7:0]  char_b [CHAR_BYTES_DEF];
  reply_beat_t replies_due [$];
  reply_beat_t fresh [$];
  int          errors;

  function new();
    configured = 0;
    uart_on = 0;
    dtr_seen = 0;
    addr_ok = 0;
    addr = '0;
    capture = CAP_NONE;
    foreach (baud_b[i]) baud_b[i] = '0;
    foreach (char_b[i]) char_b[i] = '0;
    errors = 0;
  endfunction

  function void push(act_e a, logic [7:0] d);
    reply_beat_t b;
    b = '0;
    b.act = a;
    b.data = d;
    fresh.push_back(b);
  endfunction

  // Works out every reply beat of one accepted control event.
  function void note_request(ctrl_event_t ev);
    logic [15:0] tag;
    int          n;
    int          idx;
    fresh.delete();
    case (ev.mode)
      MODE_SETUP: begin
        if (ev.rtype == TYPE_CLASS) begin
          push(ACT_ZLP, 8'h00);
        end else begin
          capture = CAP_NONE;
          tag = {ev.rtype, ev.code};
          case (tag)
            TAG_GET_DESC: begin
              case (ev.value[15:8])
                DESC_DEVICE: for (int i = 0; i < 18; i++) push(ACT_DATA, DEVICE_BYTES[i]);
                DESC_QUALIFIER: push(ACT_ZLP, 8'h00);
                DESC_CONFIG: begin
                  n = (ev.length < 32) ? int'(ev.length) : 32;
                  if (n == 0) push(ACT_ZLP, 8'h00);
                  for (int i = 0; i < n; i++) push(ACT_DATA, CONFIG_BYTES[i]);
                end
                DESC_STRING: begin
                  idx = int'(ev.value[7:0]);
                  if (idx == 0) begin
                    for (int i = 0; i < 4; i++) push(ACT_DATA, LANGUAGE_BYTES[i]);
                  end else if (idx > 3) begin
                    push(ACT_ERR, 8'h00);
                  end else begin
                    n = TEXT_CHARS[idx-1];
                    if (n > MAX_STRING_CHARS_DEF) n = MAX_STRING_CHARS_DEF;
                    push(ACT_DATA, 8'(2 + 2 * n));
                    push(ACT_DATA, DESC_STRING);
                    for (int i = 0; i < n; i++) begin
                      push(ACT_DATA, TEXT_BYTES[idx-1][i]);
                      push(ACT_DATA, 8'h00);
                    end
                  end
                end
                default: push(ACT_NONE, 8'h00);
              endcase
            end
            TAG_SET_ADDR: begin
              addr_ok = 1;
              addr = ev.value[6:0];
              push(ACT_ZLP, 8'h00);
            end
            TAG_SET_CONFIG: begin
              configured = 1;
              push(ACT_ZLP, 8'h00);
            end
            TAG_VEND_READ: push(ACT_DATA, 8'h02);
            TAG_UART_ENABLE: begin
              uart_on = (ev.value == 16'd1);
              push(ACT_ZLP, 8'h00);
            end
            TAG_SET_BAUD: begin
              capture = CAP_BAUD;
              push(ACT_ZLP, 8'h00);
            end
            TAG_SET_CHARS: begin
              capture = CAP_CHARS;
              push(ACT_ZLP, 8'h00);
            end
            TAG_SET_LINE, TAG_GET_STATUS: push(ACT_ZLP, 8'h00);
            TAG_GET_MODEM: push(ACT_DATA, 8'h00);
            TAG_SET_MODEM: begin
              if (ev.value[0]) dtr_seen = 1;
              push(ACT_ZLP, 8'h00);
            end
            TAG_GET_COMM: begin
              push(ACT_DATA, 8'h00);
              push(ACT_DATA, 8'h00);
            end
            default: push(ACT_NONE, 8'h00);
          endcase
        end
      end
      MODE_EMPTY_SETUP: push(ACT_NONE, 8'h00);
      MODE_DATA: begin
        if (capture == CAP_BAUD) begin
          if (ev.offset < BAUD_BYTES_DEF) baud_b[ev.offset] = ev.data;
          push(ACT_NONE, 8'h00);
        end else if (capture == CAP_CHARS) begin
          if (ev.offset < CHAR_BYTES_DEF) char_b[ev.offset] = ev.data;
          push(ACT_NONE, 8'h00);
        end else if (ev.eop) begin
          push(ACT_ZLP, 8'h00);
        end else begin
          push(ACT_NONE, 8'h00);
        end
      end
      default: begin
        if (capture != CAP_NONE) push(ACT_NONE, 8'h00);
        else push(ACT_ZLP, 8'h00);
      end
    endcase
    // Status fields carry the state after the event on every beat.
    foreach (fresh[k]) begin
      fresh[k].last = (k == fresh.size() - 1);
      fresh[k].configured = configured;
      fresh[k].uart_on = uart_on;
      fresh[k].dtr = dtr_seen;
      fresh[k].addr_ok = addr_ok;
      fresh[k].addr = addr;
      foreach (baud_b[i]) fresh[k].baud[8*i +: 8] = baud_b[i];
      foreach (char_b[i]) fresh[k].chars[8*i +: 8] = char_b[i];
      replies_due.push_back(fresh[k]);
    end
  endfunction

  function void compare(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_reply(reply_beat_t got);
    reply_beat_t want;
    if (replies_due.size() == 0) begin
      $error("reply beat with none outstanding: action %0d byte 0x%0h", got.act, got.data);
      errors++;
      return;
    end
    want = replies_due.pop_front();
    compare("action", want.act, got.act);
    compare("reply_byte", want.data, got.data);
    compare("last", want.last, got.last);
    compare("configured", want.configured, got.configured);
    compare("uart_enabled", want.uart_on, got.uart_on);
    compare("terminal_ready", want.dtr, got.dtr);
    compare("address_valid", want.addr_ok, got.addr_ok);
    compare("device_address", want.addr, got.addr);
    compare("baud_setting", want.baud, got.baud);
    compare("special_chars", want.chars, got.chars);
  endfunction
endclass

module tb_usb_control_request_responder;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [7:0]  request_type_i = '0;
  logic [7:0]  request_code_i = '0;
  logic [15:0] request_value_i = '0;
  logic [15:0] request_length_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [5:0]  byte_offset_i = '0;
  logic        end_of_packet_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  action_o;
  logic [7:0]  reply_byte_o;
  logic        last_o;
  logic        configured_o;
  logic        uart_enabled_o;
  logic        terminal_ready_o;
  logic        address_valid_o;
  logic [6:0]  device_address_o;
  logic [31:0] baud_setting_o;
  logic [47:0] special_chars_o;

  reply_tracker tracker;
  int unsigned  sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_style = 0;
  int unsigned  stall_span = 0;

  usb_control_request_responder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .request_type_i   (request_type_i),
    .request_code_i   (request_code_i),
    .request_value_i  (request_value_i),
    .request_length_i (request_length_i),
    .data_byte_i      (data_byte_i),
    .byte_offset_i    (byte_offset_i),
    .end_of_packet_i  (end_of_packet_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .reply_byte_o     (reply_byte_o),
    .last_o           (last_o),
    .configured_o     (configured_o),
    .uart_enabled_o   (uart_enabled_o),
    .terminal_ready_o (terminal_ready_o),
    .address_valid_o  (address_valid_o),
    .device_address_o (device_address_o),
    .baud_setting_o   (baud_setting_o),
    .special_chars_o  (special_chars_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The receiver switches at random between stall patterns.
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 300);
    end
    stall_span--;
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= (stall_span % 3 == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk_i) begin
    reply_beat_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.act = act_e'(action_o);
      seen.data = reply_byte_o;
      seen.last = last_o;
      seen.configured = configured_o;
      seen.uart_on = uart_enabled_o;
      seen.dtr = terminal_ready_o;
      seen.addr_ok = address_valid_o;
      seen.addr = device_address_o;
      seen.baud = baud_setting_o;
      seen.chars = special_chars_o;
      tracker.check_reply(seen);
    end
  end

  function automatic ctrl_event_t noise_event();
    ctrl_event_t ev;
    ev.mode = mode_e'($urandom_range(0, 3));
    ev.rtype = 8'($urandom);
    ev.code = 8'($urandom);
    ev.value = 16'($urandom);
    ev.length = 16'($urandom);
    ev.data = 8'($urandom);
    ev.offset = 6'($urandom);
    ev.eop = 1'($urandom);
    return ev;
  endfunction

  function automatic ctrl_event_t setup_event(logic [15:0] tag, logic [15:0] value,
                                              logic [15:0] length);
    ctrl_event_t ev;
    ev = noise_event();
    ev.mode = MODE_SETUP;
    {ev.rtype, ev.code} = tag;
    ev.value = value;
    ev.length = length;
    return ev;
  endfunction

  function automatic ctrl_event_t data_event(logic [7:0] data, logic [5:0] offset, logic eop);
    ctrl_event_t ev;
    ev = noise_event();
    ev.mode = MODE_DATA;
    ev.data = data;
    ev.offset = offset;
    ev.eop = eop;
    return ev;
  endfunction

  function automatic ctrl_event_t bare_event(mode_e mode);
    ctrl_event_t ev;
    ev = noise_event();
    ev.mode = mode;
    return ev;
  endfunction

  function automatic ctrl_event_t known_setup();
    logic [15:0] tag;
    logic [15:0] value;
    logic [15:0] length;
    tag = ($urandom_range(0, 1) == 1) ? TAG_GET_DESC : KNOWN_TAGS[$urandom_range(0, 11)];
    value = 16'($urandom);
    length = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    if (tag == TAG_GET_DESC) begin
      case ($urandom_range(0, 5))
        0: value[15:8] = DESC_DEVICE;
        1: value[15:8] = DESC_CONFIG;
        2, 3: value[15:8] = DESC_STRING;
        4: value[15:8] = DESC_QUALIFIER;
        default: value[15:8] = 8'($urandom);
      endcase
      if ($urandom_range(0, 3) != 0) value[7:0] = 8'($urandom_range(0, 5));
    end else if (tag == TAG_UART_ENABLE && $urandom_range(0, 2) != 0) begin
      value = 16'($urandom_range(0, 1));
    end
    return setup_event(tag, value, length);
  endfunction

  // Sender works in bursts; between bursts it may drop valid after a beat.
  task automatic send_event(ctrl_event_t ev);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= ev.mode;
    request_type_i <= ev.rtype;
    request_code_i <= ev.code;
    request_value_i <= ev.value;
    request_length_i <= ev.length;
    data_byte_i <= ev.data;
    byte_offset_i <= ev.offset;
    end_of_packet_i <= ev.eop;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_request(ev);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 60);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_packet(int unsigned beats);
    logic [5:0] offset;
    for (int unsigned i = 0; i < beats; i++) begin
      offset = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'(i);
      send_event(data_event(8'($urandom), offset, i == beats - 1));
    end
  endtask

  task automatic run_directed();
    send_event(setup_event(TAG_GET_DESC, {DESC_DEVICE, 8'h00}, 16'h0001));
    send_event(setup_event(TAG_GET_DESC, {DESC_CONFIG, 8'h00}, 16'hffff));
    send_event(setup_event(TAG_GET_DESC, {DESC_CONFIG, 8'h00}, 16'h0009));
    send_event(setup_event(TAG_GET_DESC, {DESC_CONFIG, 8'h00}, 16'h0000));
    send_event(setup_event(TAG_GET_DESC, {DESC_STRING, 8'h00}, 16'h00ff));
    send_event(setup_event(TAG_GET_DESC, {DESC_STRING, 8'h02}, 16'h00ff));
    send_event(setup_event(TAG_GET_DESC, {DESC_STRING, 8'h04}, 16'h00ff));
    send_event(setup_event(TAG_GET_DESC, {DESC_STRING, 8'hff}, 16'h00ff));
    send_event(setup_event(TAG_GET_DESC, {DESC_QUALIFIER, 8'h00}, 16'h000a));
    send_event(setup_event(TAG_GET_DESC, 16'hff00, 16'h0040));
    send_event(setup_event(TAG_SET_ADDR, 16'hffff, 16'h0000));
    send_event(setup_event(TAG_SET_CONFIG, 16'h0001, 16'h0000));
    send_event(setup_event(TAG_VEND_READ, 16'h0000, 16'h0001));
    send_event(setup_event(TAG_UART_ENABLE, 16'h0001, 16'h0000));
    send_event(setup_event(TAG_SET_MODEM, 16'h0301, 16'h0000));
    send_event(setup_event(TAG_GET_COMM, 16'h0000, 16'h0013));
    // Baud capture keeps running across a class request and drops bytes past the store.
    send_event(setup_event(TAG_SET_BAUD, 16'h0000, 16'h0004));
    send_event(data_event(8'hff, 6'd0, 1'b0));
    send_event(setup_event({TYPE_CLASS, 8'h20}, 16'h0000, 16'h0007));
    send_event(data_event(8'h81, 6'd3, 1'b0));
    send_event(data_event(8'h5a, 6'd63, 1'b1));
    send_event(bare_event(MODE_EMPTY_DATA));
    send_event(setup_event(TAG_SET_CHARS, 16'h0000, 16'h0006));
    send_event(bare_event(MODE_EMPTY_SETUP));
    send_event(data_event(8'ha5, 6'd5, 1'b1));
    send_event(setup_event(TAG_GET_STATUS, 16'h0000, 16'h0002));
    send_event(data_event(8'h00, 6'd0, 1'b0));
    send_event(data_event(8'h00, 6'd1, 1'b1));
    send_event(bare_event(MODE_EMPTY_DATA));
  endtask

  initial begin
    int unsigned target;
    int unsigned halfway;
    bit          paused;
    int unsigned pick;
    tracker = new();
    paused = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    wait_drained();
    halfway = sent + 160;
    target = sent + 315;
    while (sent < target) begin
      if (!paused && sent >= halfway) begin
        wait_drained();
        paused = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_event(known_setup());
      end else if (pick < 65) begin
        send_event(setup_event(($urandom_range(0, 1) == 1) ? TAG_SET_BAUD : TAG_SET_CHARS,
                               16'($urandom), 16'($urandom)));
        send_packet($urandom_range(1, 8));
        if ($urandom_range(0, 3) == 0) send_event(bare_event(MODE_EMPTY_DATA));
        if ($urandom_range(0, 3) == 0) begin
          send_event(setup_event({TYPE_CLASS, 8'($urandom)}, 16'($urandom),
                                 16'($urandom)));
          send_packet($urandom_range(1, 8));
        end
      end else if (pick < 80) begin
        send_event(known_setup());
        send_packet($urandom_range(1, 4));
        if ($urandom_range(0, 1) == 0) send_event(bare_event(MODE_EMPTY_DATA));
        else send_event(bare_event(MODE_EMPTY_SETUP));
      end else begin
        send_event(setup_event(16'($urandom), 16'($urandom), 16'($urandom)));
        send_event(noise_event());
      end
    end
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.replies_due.size() == 0) begin
      $display("usb_control_request_responder verification clean");
    end else begin
      $display("usb_control_request_responder verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("usb_control_request_responder verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
sv/usbcrr_pkg.sv
sv/usbcrr_rom.sv
sv/usbcrr_streamer.sv
sv/usb_control_request_responder.sv
test/tb_usb_control_request_responder.sv
